### rtl/core/cbmr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the CCID bulk-out message reassembler.
// No dependencies; every file of the block but cbmr_ram imports this package.
package cbmr_pkg;

  // Default sizing of the frame buffer and the message header.
  localparam int BUFFER_BYTES_DEF = 512;
  localparam int HEADER_BYTES_DEF = 10;
  localparam int MAX_PAYLOAD_DEF  = 502;

  // Fixed field widths of the channels.
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int RIDX_W   = 9;
  localparam int STATUS_W = 2;
  localparam int FLEN_W   = 10;
  localparam int PKT_W    = 7;
  localparam int LEN_W    = 32;

  // Configuration port.
  localparam int          CFG_ADDR_W  = 3;
  localparam int          CFG_DATA_W  = 32;
  localparam logic        REG_EP_SIZE = 1'b0;
  localparam logic [PKT_W-1:0] EP_SIZE_RST = 7'd64;
  localparam logic [PKT_W-1:0] PKT_SAT     = 7'd127;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE  = 2'd0,
    CMD_ZLP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MORE    = 2'd0,
    ST_READY   = 2'd1,
    ST_DROPPED = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  // One request as held in the input register.
  typedef struct packed {
    cmd_t              command;
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_packet;
    logic [RIDX_W-1:0] read_index;
  } in_req_t;

  // Result control from the assembly core.
  typedef struct packed {
    logic    valid;
    status_t status;
  } res_ctl_t;

endpackage

### rtl/core/cbmr_in_if.sv
`timescale 1ns / 1ps
// Request channel of the reassembler: valid/ready plus the request fields.
// Depends on cbmr_pkg for field types and widths.
interface cbmr_in_if;
  import cbmr_pkg::*;

  logic              valid;
  logic              ready;
  cmd_t              command;
  logic [BYTE_W-1:0] data_byte;
  logic              last_of_packet;
  logic [RIDX_W-1:0] read_index;

  modport source (output valid, command, data_byte, last_of_packet, read_index,
                  input ready);
  modport sink   (input valid, command, data_byte, last_of_packet, read_index,
                  output ready);
endinterface

### rtl/core/cbmr_out_if.sv
`timescale 1ns / 1ps
// Result channel of the reassembler: valid/ready plus the result fields.
// Depends on cbmr_pkg for field types and widths.
interface cbmr_out_if;
  import cbmr_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [FLEN_W-1:0] frame_length;
  logic [BYTE_W-1:0] read_byte;

  modport source (output valid, status, frame_length, read_byte, input ready);
  modport sink   (input valid, status, frame_length, read_byte, output ready);
endinterface

### rtl/core/cbmr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

### rtl/core/cbmr_apb_regs.sv
`timescale 1ns / 1ps
// APB-style configuration register: the endpoint packet size.
// Depends on cbmr_pkg for address layout and reset value.
module cbmr_apb_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbmr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cbmr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cbmr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [cbmr_pkg::PKT_W-1:0]      ep_size
);
  import cbmr_pkg::*;

  logic [PKT_W-1:0] ep_size_r;
  logic [PKT_W-1:0] ep_size_nxt;
  logic             reg_sel;
  logic             wr_en;

  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_EP_SIZE);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  always_comb begin
    ep_size_nxt = ep_size_r;
    if (wr_en) begin
      ep_size_nxt = pwdata[PKT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_size_r <= EP_SIZE_RST;
    end else begin
      ep_size_r <= ep_size_nxt;
    end
  end

  assign pready  = 1'b1;
  assign prdata  = reg_sel ? CFG_DATA_W'(ep_size_r) : '0;
  assign ep_size = ep_size_r;
endmodule

### rtl/core/cbmr_core.sv
`timescale 1ns / 1ps
// Assembly state and packet judgment for one request per cycle while fire is high.
// Depends on cbmr_pkg; drives the frame buffer write port.
module cbmr_core #(
  parameter int BUFFER_BYTES = cbmr_pkg::BUFFER_BYTES_DEF,
  parameter int HEADER_BYTES = cbmr_pkg::HEADER_BYTES_DEF,
  parameter int MAX_PAYLOAD  = cbmr_pkg::MAX_PAYLOAD_DEF,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int CW = $clog2(BUFFER_BYTES + 128)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  cbmr_pkg::in_req_t            req,
  input  logic [cbmr_pkg::PKT_W-1:0]   ep_size,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [cbmr_pkg::BYTE_W-1:0]  mem_wdata,
  output cbmr_pkg::res_ctl_t           res,
  output logic [CW-1:0]                asm_len
);
  import cbmr_pkg::*;

  localparam int PW        = CW + 1;
  localparam int LEN_LIMIT = (MAX_PAYLOAD < BUFFER_BYTES - HEADER_BYTES) ?
                             MAX_PAYLOAD : BUFFER_BYTES - HEADER_BYTES;
  localparam logic [CW-1:0] HDR = CW'(HEADER_BYTES);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    exp_r, exp_nxt;
  logic             discard_r, discard_nxt;
  logic [PKT_W-1:0] pkt_r, pkt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] lf_r, lf_nxt;

  logic [PKT_W-1:0] pkt_inc;
  logic [PW-1:0]    pos;
  logic             is_byte;
  logic             byte_take;
  logic             byte_wr;
  logic             byte_ovf;
  logic [1:0]       lane;
  logic [LEN_W-1:0] lf_j;
  logic             ovf_j;
  logic             judge;
  logic [PKT_W-1:0] plen;
  logic [CW-1:0]    cnt2;
  logic             short_pkt;
  logic             need_hdr;
  logic             lf_bad;
  logic [CW-1:0]    exp_cand;
  logic             mal;
  logic [CW-1:0]    mal_cnt;
  status_t          st;

  assign is_byte   = (req.command == CMD_BYTE);
  assign pkt_inc   = (pkt_r != PKT_SAT) ? pkt_r + PKT_W'(1) : pkt_r;
  assign pos       = {1'b0, cnt_r} + PW'(pkt_inc) - PW'(1);
  assign byte_take = is_byte && !discard_r && (pkt_inc <= ep_size);
  assign byte_wr   = byte_take && (pos < PW'(BUFFER_BYTES));
  assign byte_ovf  = byte_take && !(pos < PW'(BUFFER_BYTES));
  assign lane      = pos[1:0] - 2'd1;

  // Capture header bytes 1 to 4 as the little-endian payload length.
  always_comb begin
    lf_j = lf_r;
    if (byte_wr && pos >= PW'(1) && pos <= PW'(4)) begin
      case (lane)
        2'd0:    lf_j[7:0]   = req.data_byte;
        2'd1:    lf_j[15:8]  = req.data_byte;
        2'd2:    lf_j[23:16] = req.data_byte;
        default: lf_j[31:24] = req.data_byte;
      endcase
    end
  end

  assign ovf_j     = ovf_r | byte_ovf;
  assign judge     = (is_byte && req.last_of_packet) || (req.command == CMD_ZLP);
  assign plen      = is_byte ? pkt_inc : pkt_r;
  assign cnt2      = cnt_r + CW'(plen);
  assign short_pkt = (plen < ep_size);
  assign need_hdr  = (exp_r == '0) && (cnt2 >= HDR);
  assign lf_bad    = (lf_j > LEN_W'(LEN_LIMIT));
  assign exp_cand  = need_hdr ? HDR + lf_j[CW-1:0] : exp_r;

  always_comb begin
    cnt_nxt     = cnt_r;
    exp_nxt     = exp_r;
    discard_nxt = discard_r;
    pkt_nxt     = pkt_r;
    ovf_nxt     = ovf_r;
    lf_nxt      = lf_r;
    st          = ST_MORE;
    mal         = 1'b0;
    mal_cnt     = cnt_r;

    case (req.command)
      CMD_BYTE: begin
        pkt_nxt = pkt_inc;
        ovf_nxt = ovf_j;
        lf_nxt  = lf_j;
      end
      CMD_CLEAR: begin
        cnt_nxt     = '0;
        exp_nxt     = '0;
        discard_nxt = 1'b0;
        pkt_nxt     = '0;
        ovf_nxt     = 1'b0;
      end
      CMD_READ: begin
        st = ST_READ;
      end
      default: ;
    endcase

    if (judge) begin
      pkt_nxt = '0;
      ovf_nxt = 1'b0;
      if (ep_size == '0 || plen > ep_size) begin
        cnt_nxt     = '0;
        exp_nxt     = '0;
        discard_nxt = 1'b0;
        st          = ST_DROPPED;
      end else if (discard_r || plen == '0 || ovf_j) begin
        mal = 1'b1;
      end else begin
        cnt_nxt = cnt2;
        mal_cnt = cnt2;
        if (need_hdr && lf_bad) begin
          mal = 1'b1;
        end else begin
          exp_nxt = exp_cand;
          if (exp_cand != '0 && cnt2 > exp_cand) begin
            mal = 1'b1;
          end else if (exp_cand != '0 && cnt2 == exp_cand) begin
            st = ST_READY;
          end else if (short_pkt) begin
            mal = 1'b1;
          end else begin
            st = ST_MORE;
          end
        end
      end

      // Malformed: drop without a full header, else end or discard the rest.
      if (mal) begin
        if (mal_cnt < HDR) begin
          cnt_nxt     = '0;
          exp_nxt     = '0;
          discard_nxt = 1'b0;
          st          = ST_DROPPED;
        end else if (short_pkt) begin
          st = ST_READY;
        end else begin
          discard_nxt = 1'b1;
          st          = ST_MORE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      exp_r     <= '0;
      discard_r <= 1'b0;
      pkt_r     <= '0;
      ovf_r     <= 1'b0;
      lf_r      <= '0;
    end else if (fire) begin
      cnt_r     <= cnt_nxt;
      exp_r     <= exp_nxt;
      discard_r <= discard_nxt;
      pkt_r     <= pkt_nxt;
      ovf_r     <= ovf_nxt;
      lf_r      <= lf_nxt;
    end
  end

  assign mem_we     = fire && byte_wr;
  assign mem_waddr  = pos[AW-1:0];
  assign mem_wdata  = req.data_byte;
  assign res.valid  = judge || (req.command == CMD_READ);
  assign res.status = st;
  assign asm_len    = cnt_nxt;
endmodule

### rtl/core/ccid_bulk_message_reassembler.sv
`timescale 1ns / 1ps
// Top level of the CCID bulk-out message reassembler: input register,
// frame buffer, assembly core, result register. Uses cbmr_pkg and all rtl/core.
//
//   port group   dir  handshake            payload
//   in_ch        in   valid / ready        command, data_byte, last_of_packet,
//                                          read_index
//   out_ch       out  valid / ready        status, frame_length, read_byte
//   APB          in   psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// One request per cycle unless out_ch stalls; a request is accepted into the
// input register, and its result is offered from the result register.
// The rate is set by the input-register-to-result-register pass: the core
// judges a packet and writes the frame buffer in the same cycle.
// Reset is synchronous on rst_n; the frame buffer is not cleared.
// A result waiting in the result register holds the input register; an empty
// input register still takes one request, so two requests fill the block.
module ccid_bulk_message_reassembler #(
  parameter int BUFFER_BYTES = cbmr_pkg::BUFFER_BYTES_DEF,
  parameter int HEADER_BYTES = cbmr_pkg::HEADER_BYTES_DEF,
  parameter int MAX_PAYLOAD  = cbmr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cbmr_in_if.sink                         in_ch,
  cbmr_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbmr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cbmr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cbmr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import cbmr_pkg::*;

  localparam int AW  = $clog2(BUFFER_BYTES);
  localparam int CW  = $clog2(BUFFER_BYTES + 128);
  localparam int RIW = (AW > RIDX_W) ? AW : RIDX_W;

  logic              s1_v_r, s1_v_nxt;
  in_req_t           s1_req_r, s1_req_nxt;
  logic              byp_r, byp_nxt;
  logic [BYTE_W-1:0] byp_data_r, byp_data_nxt;
  logic              out_v_r, out_v_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [FLEN_W-1:0] out_flen_r, out_flen_nxt;
  logic [BYTE_W-1:0] out_rbyte_r, out_rbyte_nxt;

  logic              s1_adv;
  logic              s1_fire;
  logic              in_fire;
  logic [PKT_W-1:0]  ep_size;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  logic [RIW-1:0]    ridx_ext;
  res_ctl_t          res;
  logic [CW-1:0]     asm_len;
  logic              rd_in_range;
  logic [BYTE_W-1:0] rbyte;

  assign s1_adv      = !out_v_r || out_ch.ready;
  assign s1_fire     = s1_v_r && s1_adv;
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  cbmr_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ep_size (ep_size)
  );

  // Issue the buffer read as the request is accepted.
  assign ridx_ext  = RIW'(in_ch.read_index);
  assign mem_raddr = ridx_ext[AW-1:0];

  cbmr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cbmr_core #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_PAYLOAD  (MAX_PAYLOAD)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_fire),
    .req       (s1_req_r),
    .ep_size   (ep_size),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .res       (res),
    .asm_len   (asm_len)
  );

  always_comb begin
    s1_v_nxt     = s1_v_r;
    s1_req_nxt   = s1_req_r;
    byp_nxt      = byp_r;
    byp_data_nxt = byp_data_r;
    if (in_ch.ready) begin
      s1_v_nxt = in_ch.valid;
    end
    if (in_fire) begin
      s1_req_nxt.command        = in_ch.command;
      s1_req_nxt.data_byte      = in_ch.data_byte;
      s1_req_nxt.last_of_packet = in_ch.last_of_packet;
      s1_req_nxt.read_index     = in_ch.read_index;
      // The write of the request in the input register lands with this read: forward it.
      byp_nxt      = mem_we && (mem_waddr == mem_raddr);
      byp_data_nxt = mem_wdata;
    end
  end

  assign rd_in_range = (32'(s1_req_r.read_index) < 32'(BUFFER_BYTES));
  assign rbyte = (s1_req_r.command == CMD_READ && rd_in_range) ?
                 (byp_r ? byp_data_r : mem_rdata) : '0;

  always_comb begin
    out_v_nxt      = out_v_r;
    out_status_nxt = out_status_r;
    out_flen_nxt   = out_flen_r;
    out_rbyte_nxt  = out_rbyte_r;
    if (s1_adv) begin
      out_v_nxt = s1_v_r && res.valid;
    end
    if (s1_fire && res.valid) begin
      out_status_nxt = res.status;
      out_flen_nxt   = FLEN_W'(asm_len);
      out_rbyte_nxt  = rbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r     <= s1_req_nxt;
    byp_r        <= byp_nxt;
    byp_data_r   <= byp_data_nxt;
    out_status_r <= out_status_nxt;
    out_flen_r   <= out_flen_nxt;
    out_rbyte_r  <= out_rbyte_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.frame_length = out_flen_r;
  assign out_ch.read_byte    = out_rbyte_r;

  // Input stalls only when both stages hold work.
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && out_v_r))
    else $error("input stalled with a free stage");

  // Buffer writes stay inside the buffer.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < 32'(BUFFER_BYTES)))
    else $error("frame buffer write out of range");

  // Only a read reply carries buffer data.
  a_rbyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_status_r != ST_READ) |-> (out_rbyte_r == '0))
    else $error("read byte set on a non-read result");

  // A dropped message always reports an empty assembly.
  a_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_status_r == ST_DROPPED) |-> (out_flen_r == '0))
    else $error("dropped result with nonzero length");
endmodule
